@@ src/jnl_pkg.sv @@
// ----------------------------------------------------------------------------
// JSON number lexer package
// Shared types, character codes and the lexer transition function.
// ----------------------------------------------------------------------------
package jnl_pkg;

    localparam int BUFFER_BYTES_DEF = 256;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    // Register word indexes of the configuration port.
    localparam logic REG_MAX_LEN = 1'b0;

    localparam logic [7:0] MAX_LEN_RESET = 8'd255;

    // Character codes used by the grammar.
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    typedef enum logic [3:0] {
        LX_IDLE   = 4'd0,
        LX_START  = 4'd1,
        LX_MINUS  = 4'd2,
        LX_ZERO   = 4'd3,
        LX_INT    = 4'd4,
        LX_FRAC0  = 4'd5,
        LX_FRAC   = 4'd6,
        LX_EXP0   = 4'd7,
        LX_EXPSGN = 4'd8,
        LX_EXP    = 4'd9,
        LX_BAD    = 4'd14,
        LX_DONE   = 4'd15
    } t_lex_state;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_ACCEPT  = 3'd1,
        ST_BADCHAR = 3'd2,
        ST_TOOLONG = 3'd3,
        ST_EARLY   = 3'd4,
        ST_NOTOKEN = 3'd5
    } t_lex_status;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB) ||
               (c == CH_COMMA) || (c == CH_RBRK) || (c == CH_RBRC);
    endfunction

    function automatic logic is_exp_mark(input logic [7:0] c);
        return (c == CH_E_LO) || (c == CH_E_UP);
    endfunction

    // One step of the number grammar. LX_BAD rejects the byte, LX_DONE
    // means a terminator closed a complete number.
    function automatic t_lex_state next_lex(input t_lex_state s, input logic [7:0] c);
        t_lex_state nx;
        nx = LX_BAD;
        unique case (s)
            LX_START: begin
                if (c == CH_MINUS)     nx = LX_MINUS;
                else if (c == CH_ZERO) nx = LX_ZERO;
                else if (is_digit(c))  nx = LX_INT;
            end
            LX_MINUS: begin
                if (c == CH_ZERO)      nx = LX_ZERO;
                else if (is_digit(c))  nx = LX_INT;
            end
            LX_ZERO: begin
                if (c == CH_DOT)         nx = LX_FRAC0;
                else if (is_exp_mark(c)) nx = LX_EXP0;
                else if (is_term(c))     nx = LX_DONE;
            end
            LX_INT: begin
                if (is_digit(c))         nx = LX_INT;
                else if (c == CH_DOT)    nx = LX_FRAC0;
                else if (is_exp_mark(c)) nx = LX_EXP0;
                else if (is_term(c))     nx = LX_DONE;
            end
            LX_FRAC0: begin
                if (is_digit(c)) nx = LX_FRAC;
            end
            LX_FRAC: begin
                if (is_digit(c))         nx = LX_FRAC;
                else if (is_exp_mark(c)) nx = LX_EXP0;
                else if (is_term(c))     nx = LX_DONE;
            end
            LX_EXP0: begin
                if (is_digit(c))                           nx = LX_EXP;
                else if ((c == CH_PLUS) || (c == CH_MINUS)) nx = LX_EXPSGN;
            end
            LX_EXPSGN: begin
                if (is_digit(c)) nx = LX_EXP;
            end
            LX_EXP: begin
                if (is_digit(c))     nx = LX_EXP;
                else if (is_term(c)) nx = LX_DONE;
            end
            default: nx = LX_BAD;
        endcase
        return nx;
    endfunction

endpackage

@@ src/jnl_if.sv @@
// ----------------------------------------------------------------------------
// JSON number lexer channels
// Valid/ready channels carrying input bytes and lexer results.
// ----------------------------------------------------------------------------
interface jnl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       token_start;
    logic       input_ended;

    modport source (output valid, char_byte, token_start, input_ended, input ready);
    modport sink   (input valid, char_byte, token_start, input_ended, output ready);
endinterface

interface jnl_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] lex_status;
    logic [7:0] token_length;

    modport source (output valid, lex_status, token_length, input ready);
    modport sink   (input valid, lex_status, token_length, output ready);
endinterface

@@ src/json_number_lexer_unit.sv @@
// ----------------------------------------------------------------------------
// JSON number lexer unit
// Validates one JSON number token a byte at a time and reports its outcome.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake        Payload
//  i_in      in    valid / ready    char_byte, token_start, input_ended
//  o_out     out   valid / ready    lex_status, token_length
//  APB       in    psel / penable   max_token_length at word 0
//
// Every accepted item yields exactly one result item, held in the result
// register from the cycle after acceptance. One item can be accepted in every
// cycle, since the lexer state and length count update as the item is taken.
// The result register is the only stage; i_in.ready falls only while a result
// is held and the sink stalls. Reset is synchronous and active low and returns
// the lexer to idle with no token open and the length limit to 255.
//
module json_number_lexer_unit #(
    parameter int BUFFER_BYTES = jnl_pkg::BUFFER_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    jnl_in_if.sink                        i_in,
    jnl_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jnl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [jnl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [jnl_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);

    // The buffer holds the token plus one spare byte, so the usable length
    // never exceeds one less than its size.
    localparam logic [7:0] LIMIT_CAP = 8'(BUFFER_BYTES - 1);

    // Configuration register.
    logic [7:0] r_max_len;

    // Lexer state.
    jnl_pkg::t_lex_state r_state, n_state;
    logic [7:0]          r_count, n_count;

    // Result register.
    logic                 r_out_valid;
    jnl_pkg::t_lex_status r_out_status, n_status;
    logic [7:0]           r_out_len, n_len;

    logic                in_accept;
    logic                cfg_write;
    logic                tok_open;
    logic [7:0]          limit;
    jnl_pkg::t_lex_state base_state;
    logic [7:0]          base_count;
    jnl_pkg::t_lex_state step_state;

    // ------------------------------------------------------------------
    // Configuration port. The word index sits above the byte lane bits.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[2] == jnl_pkg::REG_MAX_LEN) begin
            prdata = {{(jnl_pkg::APB_DATA_W - 8){1'b0}}, r_max_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= jnl_pkg::MAX_LEN_RESET;
        end else if (cfg_write && (paddr[2] == jnl_pkg::REG_MAX_LEN)) begin
            r_max_len <= pwdata[7:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake. A new byte is taken whenever the result register is free
    // or is being emptied in this very cycle.
    // ------------------------------------------------------------------
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    assign tok_open = (r_state != jnl_pkg::LX_IDLE);
    assign limit    = (r_max_len > LIMIT_CAP) ? LIMIT_CAP : r_max_len;

    // A token start discards whatever was open and begins afresh with this
    // byte as the first character.
    assign base_state = i_in.token_start ? jnl_pkg::LX_START : r_state;
    assign base_count = i_in.token_start ? 8'd0 : r_count;
    assign step_state = jnl_pkg::next_lex(base_state, i_in.char_byte);

    // ------------------------------------------------------------------
    // Next state and result. End of input wins over a token start; every
    // outcome other than busy closes the token.
    // ------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = jnl_pkg::ST_NOTOKEN;
        n_len    = 8'd0;
        if (i_in.input_ended) begin
            n_state = jnl_pkg::LX_IDLE;
            if (tok_open) begin
                n_status = jnl_pkg::ST_EARLY;
                n_len    = r_count;
            end
        end else if (!i_in.token_start && !tok_open) begin
            n_state = jnl_pkg::LX_IDLE;
        end else begin
            n_count = base_count;
            n_len   = base_count;
            if (step_state == jnl_pkg::LX_BAD) begin
                n_status = jnl_pkg::ST_BADCHAR;
                n_state  = jnl_pkg::LX_IDLE;
            end else if (step_state == jnl_pkg::LX_DONE) begin
                n_status = jnl_pkg::ST_ACCEPT;
                n_state  = jnl_pkg::LX_IDLE;
            end else if (base_count >= limit) begin
                // The count stays where it is; the character is refused.
                n_status = jnl_pkg::ST_TOOLONG;
                n_state  = jnl_pkg::LX_IDLE;
            end else begin
                n_status = jnl_pkg::ST_BUSY;
                n_count  = base_count + 8'd1;
                n_len    = base_count + 8'd1;
                n_state  = step_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jnl_pkg::LX_IDLE;
            r_count <= 8'd0;
        end else if (in_accept) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_status <= n_status;
            r_out_len    <= n_len;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.lex_status   = r_out_status;
    assign o_out.token_length = r_out_len;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A byte that leaves the token in progress must leave a token open.
    a_busy_keeps_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (n_status == jnl_pkg::ST_BUSY)) |=> (r_state != jnl_pkg::LX_IDLE))
        else $error("busy result without an open token");

    // End of input always closes the lexer.
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.input_ended) |=> (r_state == jnl_pkg::LX_IDLE))
        else $error("token still open after end of input");

    // With no token open the reported length is zero.
    a_notoken_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == jnl_pkg::ST_NOTOKEN)) |-> (r_out_len == 8'd0))
        else $error("no-token result carries a length");

    // Every accepted item loads the result register.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted item produced no result");

endmodule

@@ dv/jnl_number_scoreboard.sv @@
// ----------------------------------------------------------------------------
// JSON number lexer scoreboard
// Watches the byte and result channels and the register port, predicts the
// status and length of every result item and compares them in order.
// ----------------------------------------------------------------------------
module jnl_number_scoreboard
    import jnl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    jnl_in_if                     i_in_mon,
    jnl_out_if                    i_out_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_accepted,
    output int                    o_too_long,
    output int                    o_early
);

    localparam logic [APB_ADDR_W-1:0] MAX_LEN_ADDR = {REG_MAX_LEN, 2'b00};
    localparam logic [7:0]            BUFFER_CAP   = 8'(BUFFER_BYTES_DEF - 1);

    typedef struct packed {
        t_lex_status status;
        logic [7:0]  length;
    } t_lex_verdict;

    t_lex_verdict awaited[$];
    t_lex_state   lex_now;
    logic [7:0]   chars_taken;
    logic [7:0]   length_cap;
    int           fails;
    int           checked;
    int           accepted;
    int           too_long;
    int           early;

    // Where the number grammar goes from state s on byte c, worked out by
    // character class first.
    function automatic t_lex_state grammar_step(input t_lex_state s, input logic [7:0] c);
        logic       digit;
        logic       term;
        t_lex_state nx;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        term  = (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB) ||
                (c == CH_COMMA) || (c == CH_RBRK) || (c == CH_RBRC);
        nx    = LX_BAD;
        if (digit) begin
            case (s)
                LX_START, LX_MINUS:        nx = (c == CH_ZERO) ? LX_ZERO : LX_INT;
                LX_INT:                    nx = LX_INT;
                LX_FRAC0, LX_FRAC:         nx = LX_FRAC;
                LX_EXP0, LX_EXPSGN, LX_EXP: nx = LX_EXP;
                default:                   nx = LX_BAD;
            endcase
        end else if (c == CH_DOT) begin
            if (s == LX_ZERO || s == LX_INT) nx = LX_FRAC0;
        end else if (c == CH_E_LO || c == CH_E_UP) begin
            if (s == LX_ZERO || s == LX_INT || s == LX_FRAC) nx = LX_EXP0;
        end else if (c == CH_MINUS) begin
            if (s == LX_START) nx = LX_MINUS;
            else if (s == LX_EXP0) nx = LX_EXPSGN;
        end else if (c == CH_PLUS) begin
            if (s == LX_EXP0) nx = LX_EXPSGN;
        end else if (term) begin
            if (s == LX_ZERO || s == LX_INT || s == LX_FRAC || s == LX_EXP) nx = LX_DONE;
        end
        return nx;
    endfunction

    // Advances the lexer copy by one byte and returns the result it gives.
    function automatic t_lex_verdict lex_predict(input logic [7:0] c, input logic s,
                                                 input logic e);
        logic         open_now;
        logic [7:0]   cap;
        t_lex_state   nx;
        t_lex_verdict v;
        open_now = (lex_now >= LX_START) && (lex_now <= LX_EXP);
        cap      = (length_cap > BUFFER_CAP) ? BUFFER_CAP : length_cap;
        if (e) begin
            if (open_now) begin
                v.status = ST_EARLY;
                v.length = chars_taken;
            end else begin
                v.status = ST_NOTOKEN;
                v.length = 8'd0;
            end
            lex_now = LX_IDLE;
        end else if (!s && !open_now) begin
            v.status = ST_NOTOKEN;
            v.length = 8'd0;
            lex_now  = LX_IDLE;
        end else begin
            if (s) begin
                lex_now     = LX_START;
                chars_taken = 8'd0;
            end
            nx = grammar_step(lex_now, c);
            if (nx == LX_BAD) begin
                v.status = ST_BADCHAR;
                lex_now  = LX_IDLE;
            end else if (nx == LX_DONE) begin
                v.status = ST_ACCEPT;
                lex_now  = LX_IDLE;
            end else if (chars_taken >= cap) begin
                v.status = ST_TOOLONG;
                lex_now  = LX_IDLE;
            end else begin
                v.status    = ST_BUSY;
                chars_taken = chars_taken + 8'd1;
                lex_now     = nx;
            end
            v.length = chars_taken;
        end
        return v;
    endfunction

    always @(posedge i_clk) begin : watch
        t_lex_verdict want;
        if (!i_rst_n) begin
            awaited.delete();
            lex_now     = LX_IDLE;
            chars_taken = 8'd0;
            length_cap  = MAX_LEN_RESET;
            fails       = 0;
            checked     = 0;
            accepted    = 0;
            too_long    = 0;
            early       = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == MAX_LEN_ADDR) begin
                length_cap = pwdata[7:0];
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                awaited.push_back(lex_predict(i_in_mon.char_byte, i_in_mon.token_start,
                                              i_in_mon.input_ended));
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (awaited.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result item, expected none, got status %0d length %0d",
                             $time, i_out_mon.lex_status, i_out_mon.token_length);
                end else begin
                    want = awaited.pop_front();
                    checked++;
                    if (i_out_mon.lex_status !== want.status) begin
                        fails++;
                        $display("%0t: lex_status mismatch, expected %0d, got %0d",
                                 $time, want.status, i_out_mon.lex_status);
                    end
                    if (i_out_mon.token_length !== want.length) begin
                        fails++;
                        $display("%0t: token_length mismatch, expected %0d, got %0d",
                                 $time, want.length, i_out_mon.token_length);
                    end
                    if (want.status == ST_ACCEPT) accepted++;
                    if (want.status == ST_TOOLONG) too_long++;
                    if (want.status == ST_EARLY) early++;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited.size();
        o_checked    <= checked;
        o_accepted   <= accepted;
        o_too_long   <= too_long;
        o_early      <= early;
    end

endmodule

@@ dv/tb_json_number_lexer_unit.sv @@
// ----------------------------------------------------------------------------
// JSON number lexer unit testbench
// Feeds byte streams of well-formed, broken and cut-off numbers under several
// length limits, with bursty input and a stalling receiver; a scoreboard
// beside the block predicts and checks every result item.
// ----------------------------------------------------------------------------
module tb_json_number_lexer_unit;
    import jnl_pkg::*;

    // Generous bound on the whole run: well above the slowest legal run,
    // even with every item waiting out a sparse receiver.
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 125;

    localparam logic [APB_ADDR_W-1:0] MAX_LEN_ADDR = {REG_MAX_LEN, 2'b00};

    // How the receiver paces its ready signal between long hold-offs.
    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int checked;
    int accepted;
    int too_long;
    int early;

    // Sender pacing, shared between the stimulus tasks.
    int burst_left = 0;
    bit idle_on    = 1'b1;
    int fed_count  = 0;
    // Cycles of forced receiver hold-off still to run; the receiver counts
    // it down in its own process.
    int hold_left  = 0;

    logic [7:0] spelled[$];

    jnl_in_if  in_ch();
    jnl_out_if out_ch();

    json_number_lexer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    jnl_number_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_accepted   (accepted),
        .o_too_long   (too_long),
        .o_early      (early)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Offers one item and returns at the edge where it is taken. Items come
    // in bursts of random length; before each burst, with idling on, the
    // sender may pause, so gaps land at every point of a number.
    task automatic push_byte(input logic [7:0] c, input logic s, input logic e);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = idle_on ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.char_byte   <= c;
        in_ch.token_start <= s;
        in_ch.input_ended <= e;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        fed_count++;
    endtask

    // Sends the first n bytes of the spelled text, opening a token with the
    // first of them.
    task automatic feed_spelled(input int n);
        for (int i = 0; i < n; i++) begin
            push_byte(spelled[i], i == 0, 1'b0);
        end
    endtask

    // Stops offering and waits until every result item has come back. Each
    // item's result is registered as the item is taken, so the block is
    // idle once the scoreboard has nothing outstanding.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_length_cap(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_LEN_ADDR;
        pwdata  <= APB_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] rand_digit(input int lo);
        return CH_ZERO + 8'($urandom_range(lo, 9));
    endfunction

    function automatic logic [7:0] pick_terminator();
        logic [7:0] t;
        case ($urandom_range(0, 6))
            0:       t = CH_SPACE;
            1:       t = CH_CR;
            2:       t = CH_LF;
            3:       t = CH_TAB;
            4:       t = CH_COMMA;
            5:       t = CH_RBRK;
            default: t = CH_RBRC;
        endcase
        return t;
    endfunction

    // Spells a random well-formed number: optional minus, a lone zero or a
    // run of digits, then optionally a fraction and an exponent.
    function automatic void spell_number();
        spelled.delete();
        if ($urandom_range(0, 1)) spelled.push_back(CH_MINUS);
        if ($urandom_range(0, 9) < 3) begin
            spelled.push_back(CH_ZERO);
        end else begin
            spelled.push_back(rand_digit(1));
            repeat ($urandom_range(0, 5)) spelled.push_back(rand_digit(0));
        end
        if ($urandom_range(0, 9) < 4) begin
            spelled.push_back(CH_DOT);
            repeat ($urandom_range(1, 5)) spelled.push_back(rand_digit(0));
        end
        if ($urandom_range(0, 9) < 4) begin
            spelled.push_back($urandom_range(0, 1) ? CH_E_UP : CH_E_LO);
            case ($urandom_range(0, 2))
                0:       spelled.push_back(CH_PLUS);
                1:       spelled.push_back(CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(1, 4)) spelled.push_back(rand_digit(0));
        end
    endfunction

    // The receiver runs in modes of random length: always ready, random,
    // a repeating bit pattern, or mostly stalled. A requested hold-off
    // overrides all of them until it has been counted down.
    initial begin : rx_pacing
        t_rx_mode   rx_mode;
        int         mode_left;
        logic [7:0] rx_pattern;
        int         pat_pos;
        rx_mode    = RX_FREE;
        mode_left  = 0;
        rx_pattern = 8'hFF;
        pat_pos    = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    rx_mode    = t_rx_mode'($urandom_range(0, 3));
                    mode_left  = $urandom_range(40, 200);
                    rx_pattern = 8'($urandom_range(1, 255));
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:    out_ch.ready <= 1'b1;
                    RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 99) < 70);
                    RX_PATTERN: begin
                        out_ch.ready <= rx_pattern[pat_pos];
                        pat_pos = (pat_pos + 1) % 8;
                    end
                    default:    out_ch.ready <= ($urandom_range(0, 99) < 25);
                endcase
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("json_number_lexer_unit test failed");
        $finish;
    end

    initial begin : stimulus
        int         phase;
        int         token_items;
        int         pick;
        int         cut;
        int         limits_tried;
        logic [7:0] cap;

        in_ch.valid       <= 1'b0;
        in_ch.char_byte   <= 8'h00;
        in_ch.token_start <= 1'b0;
        in_ch.input_ended <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        i_rst_n           <= 1'b0;
        limits_tried = 1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset limit of 255.
        // A stray byte and an end of input with no token open are both
        // reported as nothing open; end of input wins over a token start.
        push_byte(8'h78, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b1);
        push_byte(8'h00, 1'b1, 1'b1);
        // Signed zero with an exponent straight after the leading zero.
        push_byte(CH_MINUS, 1'b1, 1'b0);
        push_byte(CH_ZERO, 1'b0, 1'b0);
        push_byte(CH_E_LO, 1'b0, 1'b0);
        push_byte(CH_PLUS, 1'b0, 1'b0);
        push_byte(CH_NINE, 1'b0, 1'b0);
        push_byte(CH_RBRK, 1'b0, 1'b0);
        // Integer, fraction and signed exponent, closed by a tab.
        push_byte(CH_NINE, 1'b1, 1'b0);
        push_byte(CH_DOT, 1'b0, 1'b0);
        push_byte(CH_ZERO, 1'b0, 1'b0);
        push_byte(CH_E_UP, 1'b0, 1'b0);
        push_byte(CH_MINUS, 1'b0, 1'b0);
        push_byte(CH_ZERO, 1'b0, 1'b0);
        push_byte(CH_TAB, 1'b0, 1'b0);
        // A digit after a leading zero is rejected.
        push_byte(CH_ZERO, 1'b1, 1'b0);
        push_byte(CH_ZERO, 1'b0, 1'b0);
        // Restart while a token is open, then the input ends early.
        push_byte(CH_ZERO + 8'd1, 1'b1, 1'b0);
        push_byte(CH_NINE, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        // Top byte value as a first character, then a dot with no digits.
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(CH_ZERO, 1'b1, 1'b0);
        push_byte(CH_DOT, 1'b0, 1'b0);
        push_byte(CH_COMMA, 1'b0, 1'b0);

        // Random part: one phase per length limit, the extremes among them.
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       cap = 8'd1;
                1:       cap = 8'd0;
                2:       cap = 8'($urandom_range(2, 12));
                3:       cap = 8'd128;
                4:       cap = 8'($urandom_range(13, 40));
                default: cap = 8'd255;
            endcase
            drain_block();
            write_length_cap(cap);
            limits_tried++;

            // Two phases open with a long receiver hold-off while the sender
            // keeps offering without gaps, so the block backs up and stalls
            // its input; the others idle at random.
            if (phase == 2 || phase == 5) begin
                idle_on   = 1'b0;
                hold_left = 60;
            end else begin
                idle_on = ($urandom_range(0, 3) != 0);
            end

            // At the widest limit, one number of 258 digits runs past the
            // 255-character limit.
            if (phase == 5) begin
                spelled.delete();
                spelled.push_back(CH_ZERO + 8'd1);
                repeat (257) spelled.push_back(CH_ZERO + 8'd3);
                spelled.push_back(pick_terminator());
                feed_spelled(spelled.size());
            end

            token_items = 0;
            while (token_items < PHASE_ITEMS) begin
                spell_number();
                pick = $urandom_range(0, 99);
                if (pick < 68) begin
                    // Well-formed number with its terminator.
                    spelled.push_back(pick_terminator());
                    feed_spelled(spelled.size());
                    token_items += spelled.size();
                end else if (pick < 78) begin
                    // One byte replaced by anything at all.
                    spelled.push_back(pick_terminator());
                    cut = $urandom_range(0, spelled.size() - 1);
                    spelled[cut] = 8'($urandom_range(0, 255));
                    feed_spelled(spelled.size());
                    token_items += spelled.size();
                end else if (pick < 86) begin
                    // Cut short by the end of input, token start or not.
                    cut = $urandom_range(0, spelled.size() - 1);
                    feed_spelled(cut);
                    push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                    token_items += cut + 1;
                end else if (pick < 92) begin
                    // Left open, so the next number restarts over it.
                    cut = $urandom_range(1, spelled.size());
                    feed_spelled(cut);
                    token_items += cut;
                end else begin
                    // Noise between numbers.
                    repeat ($urandom_range(1, 3)) begin
                        push_byte(8'($urandom_range(0, 255)), 1'b0,
                                  1'($urandom_range(0, 9) == 0));
                    end
                end
            end
        end

        drain_block();
        repeat (4) @(posedge i_clk);

        $display("Fed %0d bytes under %0d length limits from 0 to 255 with bursty input",
                 fed_count, limits_tried);
        $display("and a stalling receiver: %0d results, %0d numbers, %0d overruns, %0d cut off.",
                 checked, accepted, too_long, early);
        if (fail_count == 0 && pending == 0) begin
            $display("json_number_lexer_unit test passed");
        end else begin
            $display("json_number_lexer_unit test failed");
        end
        $finish;
    end

endmodule
